// ===== rtl/bprb_pkg.sv =====
// shared types and constants for the byte pipe ring buffer
package bprb_pkg;

  localparam int unsigned PipeDepth = 1024;
  localparam int unsigned IdxW      = $clog2(PipeDepth);
  localparam int unsigned CntW      = 11;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned OpW       = 2;
  localparam int unsigned StatusW   = 3;

  typedef enum logic [OpW-1:0] {
    OpWrite  = 2'd0,
    OpRead   = 2'd1,
    OpWClose = 2'd2,
    OpRClose = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StOk           = 3'd0,
    StNotConnected = 3'd1,
    StClosed       = 3'd2,
    StFull         = 3'd3,
    StEmpty        = 3'd4,
    StEnd          = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CtrlIdle    = 2'd0,
    CtrlExec    = 2'd1,
    CtrlRespond = 2'd2
  } ctrl_state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;     // capture the request fields
    logic exec;     // evaluate the request and update pipe state
    logic respond;  // present the result for one cycle
  } ctrl_cmd_t;

endpackage

// ===== rtl/bprb_ctrl.sv =====
// controller state machine for the byte pipe ring buffer
module bprb_ctrl
  import bprb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  output ctrl_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CtrlIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CtrlIdle:    if (start) state_d = CtrlExec;
      CtrlExec:    state_d = CtrlRespond;
      CtrlRespond: state_d = CtrlIdle;
      default:     state_d = CtrlIdle;
    endcase
  end

  always_comb begin
    busy  = 1'b1;
    cmd_o = '0;
    unique case (state_q)
      CtrlIdle: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      CtrlExec:    cmd_o.exec = 1'b1;
      CtrlRespond: cmd_o.respond = 1'b1;
      default:     busy = 1'b1;
    endcase
  end

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> cmd_o.exec)
    else $error("accepted request did not reach execute");

  a_exec_respond: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> cmd_o.respond)
    else $error("execute not followed by respond");

  a_respond_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.respond |=> !busy)
    else $error("controller not free after respond");

endmodule

// ===== rtl/bprb_datapath.sv =====
// pipe state, byte store and result formation for the byte pipe ring buffer
module bprb_datapath
  import bprb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_cmd_t          cmd_i,
  input  logic               connected_i,
  input  logic [OpW-1:0]     opcode_i,
  input  logic [ByteW-1:0]   write_byte_i,
  output logic [ByteW-1:0]   read_byte_o,
  output logic [StatusW-1:0] status_o,
  output logic [CntW-1:0]    bytes_available_o
);

  logic [ByteW-1:0] mem [PipeDepth];

  op_e              op_q;
  logic [ByteW-1:0] wbyte_q;
  logic [ByteW-1:0] rdata_q;

  logic [IdxW-1:0] widx_q, widx_d, ridx_q, ridx_d;
  logic            empty_q, empty_d;
  logic            wclosed_q, wclosed_d;
  logic            rclosed_q, rclosed_d;
  status_e         status_q, status_d;
  logic            rd_ok_q, rd_ok_d;

  logic            mem_we, mem_re;
  logic [IdxW-1:0] mem_waddr;
  logic [IdxW-1:0] ridx_inc;
  logic [IdxW-1:0] idx_diff;
  logic            full;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_e'(opcode_i);
      wbyte_q <= write_byte_i;
    end
  end

  assign full     = !empty_q && (widx_q == ridx_q);
  assign ridx_inc = ridx_q + IdxW'(1);

  always_comb begin
    widx_d    = widx_q;
    ridx_d    = ridx_q;
    empty_d   = empty_q;
    wclosed_d = wclosed_q;
    rclosed_d = rclosed_q;
    status_d  = status_q;
    rd_ok_d   = rd_ok_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = empty_q ? '0 : widx_q;
    if (cmd_i.exec) begin
      status_d = StOk;
      rd_ok_d  = 1'b0;
      case (op_q)
        OpWrite: begin
          if (!connected_i) begin
            status_d = StNotConnected;
          end else if (wclosed_q || rclosed_q) begin
            status_d = StClosed;
          end else if (full) begin
            status_d = StFull;
          end else begin
            mem_we  = 1'b1;
            widx_d  = mem_waddr + IdxW'(1);
            if (empty_q) ridx_d = '0;
            empty_d = 1'b0;
          end
        end
        OpRead: begin
          if (!connected_i) begin
            status_d = StNotConnected;
          end else if (rclosed_q) begin
            status_d = StClosed;
          end else if (empty_q) begin
            status_d = wclosed_q ? StEnd : StEmpty;
          end else begin
            mem_re  = 1'b1;
            rd_ok_d = 1'b1;
            ridx_d  = ridx_inc;
            if (ridx_inc == widx_q) empty_d = 1'b1;
          end
        end
        OpWClose: wclosed_d = 1'b1;
        default: begin
          rclosed_d = 1'b1;
          empty_d   = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q    <= '0;
      ridx_q    <= '0;
      empty_q   <= 1'b1;
      wclosed_q <= 1'b0;
      rclosed_q <= 1'b0;
      status_q  <= StOk;
      rd_ok_q   <= 1'b0;
    end else begin
      widx_q    <= widx_d;
      ridx_q    <= ridx_d;
      empty_q   <= empty_d;
      wclosed_q <= wclosed_d;
      rclosed_q <= rclosed_d;
      status_q  <= status_d;
      rd_ok_q   <= rd_ok_d;
    end
  end

  // byte store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= wbyte_q;
    if (mem_re) rdata_q <= mem[ridx_q];
  end

  // index distance wraps modulo the depth; equal indices on a non-empty pipe mean full
  assign idx_diff          = widx_q - ridx_q;
  assign read_byte_o       = rd_ok_q ? rdata_q : '0;
  assign status_o          = status_q;
  assign bytes_available_o = empty_q ? '0 : {(widx_q == ridx_q), idx_diff};

  a_write_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> !empty_q)
    else $error("pipe still empty after a stored byte");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.respond && status_q == StFull) |-> bytes_available_o == CntW'(PipeDepth))
    else $error("full status without full count");

  a_byte_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_ok_q |-> status_q == StOk)
    else $error("read byte valid with failing status");

endmodule

// ===== rtl/byte_pipe_ring_buffer_top.sv =====
// top level of the byte pipe ring buffer
// a request taken at a start edge moves through the execute and then the respond state,
// where its result strobe is given; no new request is taken before that ends, busy is high
// after acceptance while the store is accessed and the result is shown
// done_o is a one-cycle strobe, the receiver cannot stall it
// reset (rst_ni low, asynchronous) empties the pipe, clears both close flags and
// the connection register; the byte store itself is not cleared
module byte_pipe_ring_buffer_top
  import bprb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration: pipe connected flag
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  // request side
  input  logic               start,
  output logic               busy,
  input  logic [OpW-1:0]     opcode_i,
  input  logic [ByteW-1:0]   write_byte_i,
  // result side
  output logic               done_o,
  output logic [ByteW-1:0]   read_byte_o,
  output logic [StatusW-1:0] status_o,
  output logic [CntW-1:0]    bytes_available_o
);

  ctrl_cmd_t cmd;
  logic      connected_q;

  // connection register; the user must write it only while no request is in flight, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      connected_q <= 1'b0;
    end else if (cfg_we_i) begin
      connected_q <= cfg_wdata_i;
    end
  end

  // sequencing of each request: capture, execute, respond
  bprb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  // indices, flags, byte store and result registers
  bprb_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .connected_i       (connected_q),
    .opcode_i          (opcode_i),
    .write_byte_i      (write_byte_i),
    .read_byte_o       (read_byte_o),
    .status_o          (status_o),
    .bytes_available_o (bytes_available_o)
  );

  // result strobe comes straight from the respond command
  assign done_o = cmd.respond;

endmodule
